[src/assert_macros.svh]
// Assertion macros for the checker file of the activation unit.
// Holds only macro definitions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, held off while reset is asserted.
`define NAU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Concurrent assertion that also holds across reset.
`define NAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/nau_pkg.sv]
// Shared types, constants and elaboration-time exponent tables for the activation unit.
// No dependencies.
package nau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int LEAK_W     = 16;
  localparam int SLOPE_W    = 17;
  localparam int CMD_W      = 2;

  localparam int OUT_FW = DATA_WIDTH + SLOPE_W;
  localparam int OUT_TW = ((OUT_FW + 7) / 8) * 8;

  localparam logic [LEAK_W-1:0]  LEAK_RESET = 16'd655;
  localparam logic [SLOPE_W-1:0] SLOPE_ONE  = 17'h10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SIGMOID = 2'd0,
    CMD_RELU    = 2'd1,
    CMD_LEAKY   = 2'd2
  } cmd_t;

  // e^-|x| is held in unsigned Q1.EF, the quotient 1/(1+e) in Q0.QF
  localparam int EF  = 48;
  localparam int EW  = EF + 1;
  localparam int SPL = EF / 2;
  localparam int HW  = EW - SPL;
  localparam int PW  = 2 * EF + 1;
  localparam int DW  = EF + 2;
  localparam int RW  = DW + 1;
  localparam int QF  = 40;

  localparam int ACT_W = FRAC_BITS + 1;
  localparam int S16_W = 17;

  localparam int HI_N = (1 << (DATA_WIDTH - 1 - 8)) + 1;
  localparam int LO_N = 256;

  typedef logic [EW-1:0] hi_tab_t [HI_N];
  typedef logic [EW-1:0] lo_tab_t [LO_N];

  localparam int QB = 60;
  localparam logic [63:0] Q_ONE = 64'd1 << QB;

  // Elaboration-time helpers only: they build the constant tables below.
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[QB+63:QB];
  endfunction

  // e^-(2^-FRAC_BITS) in Q60 by a short alternating series
  function automatic logic [63:0] exp_unit();
    logic [63:0] f1, f2, f3, f4;
    f1 = Q_ONE >> FRAC_BITS;
    f2 = qmul(f1, f1);
    f3 = qmul(f2, f1);
    f4 = qmul(f3, f1);
    return Q_ONE - f1 + f2 / 2 - f3 / 6 + f4 / 24;
  endfunction

  function automatic logic [EW-1:0] q60_round(input logic [63:0] t);
    logic [63:0] r;
    r = t + (64'd1 << (QB - EF - 1));
    return r[QB:QB-EF];
  endfunction

  // e^-(k * 256 * 2^-FRAC_BITS)
  function automatic hi_tab_t build_hi();
    hi_tab_t     tab;
    logic [63:0] c, h, t;
    c = exp_unit();
    h = Q_ONE;
    for (int i = 0; i < LO_N; i++) h = qmul(h, c);
    t = Q_ONE;
    for (int k = 0; k < HI_N; k++) begin
      tab[k] = q60_round(t);
      t = qmul(t, h);
    end
    return tab;
  endfunction

  // e^-(j * 2^-FRAC_BITS)
  function automatic lo_tab_t build_lo();
    lo_tab_t     tab;
    logic [63:0] c, t;
    c = exp_unit();
    t = Q_ONE;
    for (int j = 0; j < LO_N; j++) begin
      tab[j] = q60_round(t);
      t = qmul(t, c);
    end
    return tab;
  endfunction

  localparam hi_tab_t EXP_HI = build_hi();
  localparam lo_tab_t EXP_LO = build_lo();

  // Per-item sideband that rides along the sigmoid datapath
  typedef struct packed {
    logic                  is_sig;
    logic                  neg;
    logic [DATA_WIDTH-1:0] alt_act;
    logic [SLOPE_W-1:0]    alt_slope;
  } side_t;

  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] act;
    logic [SLOPE_W-1:0]    slope;
  } res_t;

endpackage

[src/nau_exp.sv]
// Front end: |x|, exponent table lookup, split 49x49 product to form 1+e^-|x|,
// and the ReLU / leaky ReLU results. Depends on nau_pkg.
module nau_exp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [nau_pkg::CMD_W-1:0]       in_cmd,
  input  logic [nau_pkg::DATA_WIDTH-1:0]  in_x,
  input  logic [nau_pkg::LEAK_W-1:0]      leak,
  output logic                            out_valid,
  output logic [nau_pkg::DW-1:0]          out_d,
  output nau_pkg::side_t                  out_side
);
  import nau_pkg::*;

  // stage 1: magnitude, table reads, leak product
  logic                    v1_r;
  logic [EW-1:0]           a1_r, b1_r;
  logic                    neg1_r;
  logic [CMD_W-1:0]        cmd1_r;
  logic [DATA_WIDTH-1:0]   x1_r;
  logic [2*LEAK_W-1:0]     lp1_r;
  logic [LEAK_W-1:0]       leak1_r;
  logic [DATA_WIDTH-1:0]   mag;

  assign mag = in_x[DATA_WIDTH-1] ? (~in_x + 1'b1) : in_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= EXP_HI[mag[DATA_WIDTH-1:8]];
      b1_r    <= EXP_LO[mag[7:0]];
      neg1_r  <= in_x[DATA_WIDTH-1];
      cmd1_r  <= in_cmd;
      x1_r    <= in_x;
      lp1_r   <= mag * leak;
      leak1_r <= leak;
    end
  end

  // stage 2: partial products, non-sigmoid result
  logic                  v2_r;
  logic [2*SPL-1:0]      ll2_r;
  logic [SPL+HW-1:0]     lh2_r, hl2_r;
  logic [2*HW-1:0]       hh2_r;
  side_t                 side2_r, side2_nxt;
  logic                  pos;
  logic [2*LEAK_W-1:0]   lk_sum;
  logic [DATA_WIDTH-1:0] lk_act;

  assign pos    = !x1_r[DATA_WIDTH-1] && (x1_r != '0);
  assign lk_sum = lp1_r + {{LEAK_W{1'b0}}, {LEAK_W{1'b1}}};
  assign lk_act = ~lk_sum[2*LEAK_W-1:LEAK_W] + 1'b1;

  always_comb begin
    side2_nxt.is_sig    = (cmd_t'(cmd1_r) == CMD_SIGMOID);
    side2_nxt.neg       = neg1_r;
    side2_nxt.alt_act   = '0;
    side2_nxt.alt_slope = '0;
    case (cmd_t'(cmd1_r))
      CMD_RELU: begin
        if (pos) begin
          side2_nxt.alt_act   = x1_r;
          side2_nxt.alt_slope = SLOPE_ONE;
        end
      end
      CMD_LEAKY: begin
        if (pos) begin
          side2_nxt.alt_act   = x1_r;
          side2_nxt.alt_slope = SLOPE_ONE;
        end else begin
          side2_nxt.alt_act   = lk_act;
          side2_nxt.alt_slope = {1'b0, leak1_r};
        end
      end
      default: begin
        side2_nxt.alt_act   = '0;
        side2_nxt.alt_slope = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll2_r   <= a1_r[SPL-1:0]  * b1_r[SPL-1:0];
      lh2_r   <= a1_r[SPL-1:0]  * b1_r[EW-1:SPL];
      hl2_r   <= a1_r[EW-1:SPL] * b1_r[SPL-1:0];
      hh2_r   <= a1_r[EW-1:SPL] * b1_r[EW-1:SPL];
      side2_r <= side2_nxt;
    end
  end

  // stage 3: sum partials, keep Q1.EF and add one
  logic          v3_r;
  logic [DW-1:0] d3_r;
  side_t         side3_r;
  logic [PW-1:0] esum;

  assign esum = (PW'(hh2_r) << (2 * SPL)) + (PW'(lh2_r) << SPL)
              + (PW'(hl2_r) << SPL) + PW'(ll2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r    <= DW'(esum[2*EF:EF]) + (DW'(1) << EF);
      side3_r <= side2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_d     = d3_r;
  assign out_side  = side3_r;

endmodule

[src/nau_div.sv]
// Restoring reciprocal 1/(1+e), one quotient bit per pipeline stage.
// Depends on nau_pkg.
module nau_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [nau_pkg::DW-1:0] in_d,
  input  nau_pkg::side_t         in_side,
  output logic                   out_valid,
  output logic [nau_pkg::QF-1:0] out_q,
  output nau_pkg::side_t         out_side
);
  import nau_pkg::*;

  logic          vld_r  [QF];
  logic [QF-1:0] q_r    [QF];
  side_t         side_r [QF];
  logic [DW-1:0] rem_r  [QF-1];
  logic [DW-1:0] d_r    [QF-1];

  for (genvar k = 0; k < QF; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in, d_in;
    logic [QF-1:0] q_in;
    side_t         s_in;
    logic [RW-1:0] t, dx;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = DW'(1) << EF;
      assign d_in = in_d;
      assign q_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld_r[k-1];
      assign r_in = rem_r[k-1];
      assign d_in = d_r[k-1];
      assign q_in = q_r[k-1];
      assign s_in = side_r[k-1];
    end

    assign t  = {r_in, 1'b0};
    assign dx = {1'b0, d_in};
    assign ge = (t >= dx);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= {q_in[QF-2:0], ge};
        side_r[k] <= s_in;
      end
    end

    if (k < QF - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? DW'(t - dx) : DW'(t);
          d_r[k]   <= d_in;
        end
      end
    end
  end

  assign out_valid = vld_r[QF-1];
  assign out_q     = q_r[QF-1];
  assign out_side  = side_r[QF-1];

endmodule

[src/nau_post.sv]
// Back end: round the reciprocal to Q1.12 and Q1.16, mirror for negative x,
// form s(1-s) and select the result. Depends on nau_pkg.
module nau_post (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [nau_pkg::QF-1:0] in_q,
  input  nau_pkg::side_t         in_side,
  output nau_pkg::res_t          res
);
  import nau_pkg::*;

  localparam logic [ACT_W-1:0] ACT_ONE = ACT_W'(1) << FRAC_BITS;
  localparam logic [S16_W-1:0] S16_ONE = S16_W'(1) << 16;

  // stage 1: rounding and mirror
  logic             v1_r;
  logic [ACT_W-1:0] act1_r, act_nxt;
  logic [S16_W-1:0] s16_1_r, u1_r, s16_nxt;
  side_t            side1_r;
  logic [QF:0]      act_sum, s16_sum;
  logic [ACT_W-1:0] act_p;
  logic [S16_W-1:0] s16_p;

  assign act_sum = {1'b0, in_q} + ((QF+1)'(1) << (QF - FRAC_BITS - 1));
  assign s16_sum = {1'b0, in_q} + ((QF+1)'(1) << (QF - 17));
  assign act_p   = act_sum[QF:QF-FRAC_BITS];
  assign s16_p   = s16_sum[QF:QF-16];
  assign act_nxt = in_side.neg ? (ACT_ONE - act_p) : act_p;
  assign s16_nxt = in_side.neg ? (S16_ONE - s16_p) : s16_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1_r  <= act_nxt;
      s16_1_r <= s16_nxt;
      u1_r    <= S16_ONE - s16_nxt;
      side1_r <= in_side;
    end
  end

  // stage 2: derivative product and result select
  logic                  res_v_r;
  logic [DATA_WIDTH-1:0] res_act_r;
  logic [SLOPE_W-1:0]    res_slope_r;
  res_t                  res_nxt;
  logic [2*S16_W-1:0]    prod;

  assign prod = (s16_1_r * u1_r) + (2*S16_W)'(32768);

  always_comb begin
    res_nxt.valid = v1_r;
    if (side1_r.is_sig) begin
      res_nxt.act   = DATA_WIDTH'(act1_r);
      res_nxt.slope = prod[16+SLOPE_W-1:16];
    end else begin
      res_nxt.act   = side1_r.alt_act;
      res_nxt.slope = side1_r.alt_slope;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (en) begin
      res_v_r <= res_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_act_r   <= res_nxt.act;
      res_slope_r <= res_nxt.slope;
    end
  end

  assign res = {res_v_r, res_act_r, res_slope_r};

endmodule

[src/nau_obuf.sv]
// Output register with a one-item skid stage; drives the pipeline advance enable.
// Depends on nau_pkg.
module nau_obuf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nau_pkg::res_t              res,
  output logic                       pipe_en,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [nau_pkg::OUT_TW-1:0] out_tdata
);
  import nau_pkg::*;

  logic                  out_v_r, out_v_nxt;
  logic [DATA_WIDTH-1:0] out_act_r, out_act_nxt;
  logic [SLOPE_W-1:0]    out_slope_r, out_slope_nxt;
  logic                  skid_v_r, skid_v_nxt;
  logic [DATA_WIDTH-1:0] skid_act_r, skid_act_nxt;
  logic [SLOPE_W-1:0]    skid_slope_r, skid_slope_nxt;
  logic                  o_ready;

  assign pipe_en = !skid_v_r;
  assign o_ready = !out_v_r || out_tready;

  always_comb begin
    out_v_nxt      = out_v_r;
    out_act_nxt    = out_act_r;
    out_slope_nxt  = out_slope_r;
    skid_v_nxt     = skid_v_r;
    skid_act_nxt   = skid_act_r;
    skid_slope_nxt = skid_slope_r;
    if (skid_v_r) begin
      if (o_ready) begin
        out_v_nxt     = 1'b1;
        out_act_nxt   = skid_act_r;
        out_slope_nxt = skid_slope_r;
        skid_v_nxt    = 1'b0;
      end
    end else if (o_ready) begin
      out_v_nxt     = res.valid;
      out_act_nxt   = res.act;
      out_slope_nxt = res.slope;
    end else if (res.valid) begin
      skid_v_nxt     = 1'b1;
      skid_act_nxt   = res.act;
      skid_slope_nxt = res.slope;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_act_r    <= out_act_nxt;
    out_slope_r  <= out_slope_nxt;
    skid_act_r   <= skid_act_nxt;
    skid_slope_r <= skid_slope_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TW - OUT_FW){1'b0}}, out_slope_r, out_act_r};

endmodule

[src/neural_activation_unit_core.sv]
// Top level of the activation unit: sigmoid / ReLU / leaky ReLU with derivative.
// Depends on nau_pkg, nau_exp, nau_div, nau_post and nau_obuf.
//
//   channel | ports                          | contents (low bits first)
//   --------+--------------------------------+---------------------------------------
//   input   | in_tvalid/in_tready/in_tdata   | tdata: x_value (Q4.12, signed)
//           | in_tuser                       | tuser: command (0 sig, 1 relu, 2 leaky)
//   result  | out_tvalid/out_tready/out_tdata| act_value (Q4.12), act_slope (Q1.16)
//   config  | cfg_wr_en/cfg_wr_data          | leak_slope (Q0.16), resets to 655
//
// One item per cycle while the output is not stalled, fully pipelined.
// An item passes three front-end stages, the 40-stage restoring reciprocal (one
// quotient bit per stage), two back-end stages and the output register.
// Reset is synchronous and active low; it clears only the valid bits and the leak.
// A stalled output parks one item in a skid stage; only then does the whole
// pipeline hold, so in_tready comes straight from a flop.
module neural_activation_unit_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [nau_pkg::DATA_WIDTH-1:0]  in_tdata,   // [15:0] x_value
  input  logic [nau_pkg::CMD_W-1:0]       in_tuser,   // [1:0] command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nau_pkg::OUT_TW-1:0]      out_tdata,  // [15:0] act_value, [32:16] act_slope
  input  logic                            cfg_wr_en,
  input  logic [nau_pkg::LEAK_W-1:0]      cfg_wr_data // [15:0] leak_slope
);
  import nau_pkg::*;

  // leak slope register; the user must write it only while the pipe is idle (not enforced)
  logic [LEAK_W-1:0] leak_slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_slope_r <= LEAK_RESET;
    end else if (cfg_wr_en) begin
      leak_slope_r <= cfg_wr_data;
    end
  end

  // every pipeline stage advances together; hold all when the skid is full
  logic pipe_en;

  assign in_tready = pipe_en;

  // front end: 1 + e^-|x| and the non-sigmoid results
  logic          exp_valid;
  logic [DW-1:0] exp_d;
  side_t         exp_side;

  nau_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser),
    .in_x      (in_tdata),
    .leak      (leak_slope_r),
    .out_valid (exp_valid),
    .out_d     (exp_d),
    .out_side  (exp_side)
  );

  // reciprocal: q = 1/(1+e) in Q0.40
  logic          div_valid;
  logic [QF-1:0] div_q;
  side_t         div_side;

  nau_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (exp_valid),
    .in_d      (exp_d),
    .in_side   (exp_side),
    .out_valid (div_valid),
    .out_q     (div_q),
    .out_side  (div_side)
  );

  // back end: rounding, mirror for negative x, s(1-s), select
  res_t post_res;

  nau_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (div_valid),
    .in_q     (div_q),
    .in_side  (div_side),
    .res      (post_res)
  );

  // output register and skid stage
  nau_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (post_res),
    .pipe_en    (pipe_en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[src/nau_checker.sv]
// Port-level checker for the activation unit and its bind to the top level.
// Depends on assert_macros.svh and nau_pkg.
`include "assert_macros.svh"

module nau_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [nau_pkg::OUT_TW-1:0] out_tdata
);
  import nau_pkg::*;

  // a result offered and not taken stays put
  `NAU_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // reset empties the result side
  `NAU_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // a derivative of one carries no fraction bits
  `NAU_ASSERT(a_slope_range, clk, rst_n, out_tvalid && out_tdata[32] |-> out_tdata[31:16] == 16'd0, "act_slope above 1.0")

  // input back-pressure only follows a stalled result
  `NAU_ASSERT(a_bp_cause, clk, rst_n, !in_tready |-> out_tvalid && $past(out_tvalid && !out_tready), "input held without a stalled result")

endmodule

bind neural_activation_unit_core nau_checker u_nau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
